@@ sv/bam_pkg.sv @@
// ----------------------------------------------------------------------------
// bam_pkg: shared definitions for the bitmap allocation map
// Word geometry, field widths and command codes.
// ----------------------------------------------------------------------------
package bam_pkg;

	localparam int WORD_BITS     = 32;
	localparam int BIT_SEL_W     = 5;   // log2 of WORD_BITS
	localparam int MAP_WORDS_DEF = 32;
	localparam int CFG_W         = 6;
	localparam int OFF_W         = 10;
	localparam int IDX_W         = 11;
	localparam int CMD_W         = 2;

	localparam logic [CFG_W-1:0] MAP_WORDS_RST = 6'd32;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET  = 2'd0,
		CMD_GET  = 2'd1,
		CMD_FIND = 2'd2,
		CMD_RSVD = 2'd3   // unused: map untouched, all-zero result
	} cmd_t;

endpackage

@@ sv/bam_ram.sv @@
// ----------------------------------------------------------------------------
// bam_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/bitmap_allocation_map_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_allocation_map_core: bit map of slots with set, get, find-first-zero
// Path to m_tvalid: an out-of-range or unused request goes from IDLE to DONE;
//   set/get pass ST_MOD first, find-first-zero scans ST_SCAN; DONE loads the output.
// Throughput: one request at a time; find is bound by the single RAM read
//   port, one map word per cycle. A new request is taken while a result waits.
// Reset: map_words returns to 32, then a clearing pass writes zeros to all
//   MAP_WORDS words, one per cycle, with s_tready low (config still taken).
// ----------------------------------------------------------------------------
module bitmap_allocation_map_core #(
	parameter int MAP_WORDS = bam_pkg::MAP_WORDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// config: map_words
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bam_pkg::CFG_W-1:0] cfg_data,
	// request stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // [9:0] bit_offset, [10] new_value
	input  logic [1:0]                s_tuser,   // [1:0] cmd
	// result stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,   // [0] bit_value, [11:1] free_index
	output logic [0:0]                m_tuser    // [0] range_error
);

	import bam_pkg::*;

	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam logic [IDX_W-1:0] MAP_WORDS_L = IDX_W'(MAP_WORDS);
	localparam logic [AW-1:0]    LAST_ADDR   = AW'(MAP_WORDS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] map_words_q;

	// pending set/get
	logic                 is_set_q;
	logic                 val_q;
	logic [BIT_SEL_W-1:0] bit_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        clr_q;

	// find scan: issue side and returning-data side
	logic [CFG_W-1:0] issue_q;
	logic             rvld_s1;
	logic [CFG_W-1:0] chk_s1;

	// pending result and output register
	logic             res_bit_q;
	logic [IDX_W-1:0] res_free_q;
	logic             res_err_q;
	logic             out_vld_q;
	logic             out_bit_q;
	logic [IDX_W-1:0] out_free_q;
	logic             out_err_q;

	// RAM side
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// decode
	logic [CFG_W-1:0]     words;
	logic [IDX_W-1:0]     bitcount;
	logic                 in_range;
	logic                 accept;
	logic [OFF_W-1:0]     in_off;
	logic                 in_val;
	logic [AW-1:0]        off_word;
	logic                 issue_ok;
	logic [WORD_BITS-1:0] inv_word;
	logic [WORD_BITS-1:0] low_zero;
	logic [BIT_SEL_W-1:0] zero_pos;
	logic                 word_full;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_off    = s_tdata[OFF_W-1:0];
	assign in_val    = s_tdata[OFF_W];
	assign off_word  = AW'(in_off[OFF_W-1:BIT_SEL_W]);

	// words in use: the register clipped to the store depth
	assign words    = ({{(IDX_W-CFG_W){1'b0}}, map_words_q} > MAP_WORDS_L)
		? CFG_W'(MAP_WORDS) : map_words_q;
	assign bitcount = {words, {BIT_SEL_W{1'b0}}};
	assign in_range = ({1'b0, in_off} < bitcount);
	assign issue_ok = (issue_q < words);

	// lowest clear bit of the returning word: isolate lowest one of ~word,
	// then OR-encode the one-hot position
	assign inv_word  = ~ram_rdata;
	assign low_zero  = inv_word & (ram_rdata + WORD_BITS'(1));
	assign word_full = (ram_rdata == {WORD_BITS{1'b1}});

	always_comb begin
		zero_pos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low_zero[i]) begin
				zero_pos = zero_pos | BIT_SEL_W'(i);
			end
		end
	end

	assign out_free = !out_vld_q || m_tready;

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = off_word;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_re    = accept;
				ram_raddr = (cmd_t'(s_tuser) == CMD_FIND) ? '0 : off_word;
			end
			ST_MOD: begin
				// read-modify-write of one bit for set
				ram_we           = is_set_q;
				ram_wdata[bit_q] = val_q;
			end
			ST_SCAN: begin
				ram_re    = issue_ok;
				ram_raddr = AW'(issue_q);
			end
			default: begin
			end
		endcase
	end

	bam_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			map_words_q <= MAP_WORDS_RST;
			clr_q       <= '0;
			is_set_q    <= 1'b0;
			val_q       <= 1'b0;
			bit_q       <= '0;
			addr_q      <= '0;
			issue_q     <= '0;
			rvld_s1     <= 1'b0;
			chk_s1      <= '0;
			res_bit_q   <= 1'b0;
			res_free_q  <= '0;
			res_err_q   <= 1'b0;
			out_vld_q   <= 1'b0;
			out_bit_q   <= 1'b0;
			out_free_q  <= '0;
			out_err_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				map_words_q <= cfg_data;
			end

			// output valid: loaded from a finished request, else dropped once taken
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (accept) begin
						res_bit_q  <= 1'b0;
						res_free_q <= '0;
						res_err_q  <= 1'b0;
						is_set_q   <= (cmd_t'(s_tuser) == CMD_SET);
						val_q      <= in_val;
						bit_q      <= in_off[BIT_SEL_W-1:0];
						addr_q     <= off_word;
						case (cmd_t'(s_tuser))
							CMD_SET, CMD_GET: begin
								if (in_range) begin
									state_q <= ST_MOD;
								end else begin
									res_err_q <= 1'b1;
									state_q   <= ST_DONE;
								end
							end
							CMD_FIND: begin
								// word 0 read issued this cycle
								issue_q <= CFG_W'(1);
								rvld_s1 <= 1'b1;
								chk_s1  <= '0;
								if (words == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end

				ST_MOD: begin
					if (!is_set_q) begin
						res_bit_q <= ram_rdata[bit_q];
					end
					state_q <= ST_DONE;
				end

				ST_SCAN: begin
					rvld_s1 <= issue_ok;
					chk_s1  <= issue_q;
					if (issue_ok) begin
						issue_q <= issue_q + CFG_W'(1);
					end
					if (rvld_s1) begin
						if (!word_full) begin
							res_free_q <= {chk_s1, zero_pos};
							state_q    <= ST_DONE;
						end else if (chk_s1 == words - CFG_W'(1)) begin
							// every word in use is full
							res_free_q <= bitcount;
							state_q    <= ST_DONE;
						end
					end
				end

				ST_DONE: begin
					if (out_free) begin
						out_bit_q  <= res_bit_q;
						out_free_q <= res_free_q;
						out_err_q  <= res_err_q;
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0, out_free_q, out_bit_q};
	assign m_tuser  = out_err_q;

`ifndef SYNTHESIS
	// RAM is only written by the clearing pass or a set write-back
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_MOD))
		else $error("RAM write outside clear or set write-back");

	// one request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while one is in flight");

	// a range error never carries a free index or a bit value
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[11:0] == 12'd0))
		else $error("range error result with payload");

	// a non-full word seen during a scan ends the scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rvld_s1 && !word_full) |=> (state_q == ST_DONE))
		else $error("scan went past a word with a clear bit");
`endif

endmodule

@@ test/bam_checker.sv @@
// ----------------------------------------------------------------------------
// bam_checker: result predictor and scoreboard for the bitmap allocation map
// Mirrors the slot map and word count, predicts one result per accepted
// request and compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bam_checker #(
	parameter int MAP_WORDS = bam_pkg::MAP_WORDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [bam_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [15:0]               s_tdata,   // [9:0] bit_offset, [10] new_value
	input  logic [1:0]                s_tuser,   // [1:0] cmd
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [15:0]               m_tdata,   // [0] bit_value, [11:1] free_index
	input  logic [0:0]                m_tuser,   // [0] range_error
	output int                        mismatch_count,
	output int                        results_owed
);

	import bam_pkg::*;

	typedef struct packed {
		logic             bit_value;
		logic [IDX_W-1:0] free_index;
		logic             range_error;
	} map_result_t;

	map_result_t          owed_q[$];
	logic [WORD_BITS-1:0] slot_words [MAP_WORDS];
	logic [CFG_W-1:0]     words_cfg;

	always @(posedge clk or negedge arst_n) begin : track
		map_result_t      got;
		map_result_t      want;
		logic [CMD_W-1:0] cmd;
		logic [OFF_W-1:0] off;
		logic             val;
		int               words;
		int               bit_total;
		bit               found;
		if (!arst_n) begin
			foreach (slot_words[i]) slot_words[i] = '0;
			words_cfg      = MAP_WORDS_RST;
			mismatch_count = 0;
			owed_q.delete();
		end else begin
			// retire a result before logging a request taken on the same edge
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[0], m_tdata[IDX_W:1], m_tuser[0]};
				if (owed_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: bit_value=%0d free_index=%0d range_error=%0d",
							got.bit_value, got.free_index, got.range_error);
				end else begin
					want = owed_q.pop_front();
					if (got.bit_value !== want.bit_value || got.free_index !== want.free_index ||
						got.range_error !== want.range_error) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d (bit/idx/err)",
								want.bit_value, want.free_index, want.range_error,
								got.bit_value, got.free_index, got.range_error);
					end
				end
			end

			if (cfg_valid && cfg_ready)
				words_cfg = cfg_data;

			if (s_tvalid && s_tready) begin
				cmd       = s_tuser;
				off       = s_tdata[OFF_W-1:0];
				val       = s_tdata[OFF_W];
				words     = (int'(words_cfg) > MAP_WORDS) ? MAP_WORDS : int'(words_cfg);
				bit_total = words * WORD_BITS;
				want      = '0;
				case (cmd)
					CMD_SET, CMD_GET: begin
						if (int'(off) >= bit_total)
							want.range_error = 1'b1;
						else if (cmd == CMD_SET)
							slot_words[off[OFF_W-1:BIT_SEL_W]][off[BIT_SEL_W-1:0]] = val;
						else
							want.bit_value = slot_words[off[OFF_W-1:BIT_SEL_W]][off[BIT_SEL_W-1:0]];
					end
					CMD_FIND: begin
						// lowest clear bit among the words in use, else the bit count
						want.free_index = bit_total[IDX_W-1:0];
						found = 1'b0;
						for (int w = 0; w < words && !found; w++)
							for (int b = 0; b < WORD_BITS && !found; b++)
								if (!slot_words[w][b]) begin
									found           = 1'b1;
									want.free_index = IDX_W'(w * WORD_BITS + b);
								end
					end
					default: ;  // unused code: map untouched, all-zero result
				endcase
				owed_q.push_back(want);
			end
		end
		results_owed = owed_q.size();
	end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for bitmap_allocation_map_core
// Directed set/get/find requests at the edges of the offset and word count,
// then random phases over several word counts with fill sweeps, frees and
// noise, under changing back-pressure. Checking is done by bam_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import bam_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata   = '0;   // [9:0] bit_offset, [10] new_value
	logic [1:0]       s_tuser   = '0;   // [1:0] cmd
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [15:0]      m_tdata;          // [0] bit_value, [11:1] free_index
	logic [0:0]       m_tuser;          // [0] range_error

	int mismatch_count;
	int results_owed;
	int send_gap_pct  = 0;   // chance per cycle that the request side idles
	int accept_gap_pct = 0;  // chance per cycle that the result side stalls

	// word counts for the random phases: extremes, small maps that fill up,
	// and counts beyond the store
	int word_plan [10] = '{1, 32, 2, 63, 3, 0, 1, 33, 4, 16};

	bitmap_allocation_map_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	bam_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	always #5 clk = ~clk;

	// result side back-pressure, one decision per cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= accept_gap_pct);
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Present one request, idling at random first. Returns on the falling
	// edge after acceptance with tvalid still high, so a back-to-back request
	// just overwrites the data.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] off,
		input logic val);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'd0, val, off};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop requesting and wait for every owed result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
	endtask

	// word count change, only with the block idle
	task automatic write_map_words(input int words);
		drain_results();
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(words);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int r;
		int cursor;
		int bit_total;
		int off;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_gap_pct   = 18;
		accept_gap_pct = 68;

		// directed: full 32-word map after reset
		send_request(CMD_FIND, 10'd0, 1'b0);      // empty map -> 0
		send_request(CMD_GET, 10'd0, 1'b0);
		send_request(CMD_SET, 10'd0, 1'b1);
		send_request(CMD_GET, 10'd0, 1'b0);
		send_request(CMD_FIND, 10'd0, 1'b0);      // -> 1
		send_request(CMD_SET, 10'd1023, 1'b1);    // top bit of the store
		send_request(CMD_GET, 10'd1023, 1'b0);
		send_request(CMD_SET, 10'd1023, 1'b0);
		send_request(CMD_GET, 10'd1023, 1'b0);
		send_request(CMD_RSVD, 10'd1023, 1'b1);   // unused code, all-zero result
		send_request(CMD_RSVD, 10'd0, 1'b0);

		// one word: offsets past 31 are out of range, sets there are dropped
		write_map_words(1);
		send_request(CMD_GET, 10'd32, 1'b0);
		send_request(CMD_SET, 10'd32, 1'b1);
		send_request(CMD_SET, 10'd31, 1'b1);
		send_request(CMD_GET, 10'd31, 1'b0);
		send_request(CMD_SET, 10'd1023, 1'b1);
		send_request(CMD_FIND, 10'd0, 1'b0);

		// zero words: nothing addressable, find answers 0
		write_map_words(0);
		send_request(CMD_FIND, 10'd0, 1'b0);
		send_request(CMD_GET, 10'd0, 1'b0);
		send_request(CMD_SET, 10'd0, 1'b0);

		// count beyond the store clamps to 32; earlier words kept their bits
		write_map_words(63);
		send_request(CMD_GET, 10'd32, 1'b0);
		send_request(CMD_GET, 10'd31, 1'b0);
		send_request(CMD_FIND, 10'd0, 1'b0);

		// random phases
		for (int seg = 0; seg < 10; seg++) begin
			if (seg < 4) begin
				send_gap_pct   = 18;
				accept_gap_pct = 68;
			end else if (seg < 7) begin
				send_gap_pct   = 68;
				accept_gap_pct = 18;
			end else begin
				send_gap_pct   = 0;
				accept_gap_pct = 0;
			end
			write_map_words(word_plan[seg]);
			bit_total = ((word_plan[seg] > MAP_WORDS_DEF) ? MAP_WORDS_DEF : word_plan[seg]) *
				WORD_BITS;
			cursor = 0;
			for (int i = 0; i < 105; i++) begin
				if (i == 50)
					drain_results();   // let the pipeline run dry once per phase
				r = $urandom_range(0, 99);
				// mostly in-range offsets, sometimes anything the field holds
				if (bit_total > 0 && $urandom_range(0, 3) != 0)
					off = $urandom_range(0, bit_total - 1);
				else
					off = $urandom_range(0, 1023);
				if (r < 45 && cursor < bit_total) begin
					// allocation sweep: fill from the bottom so the map runs full
					send_request(CMD_SET, OFF_W'(cursor), 1'b1);
					cursor++;
				end else if (r < 65) begin
					send_request(CMD_FIND, OFF_W'($urandom_range(0, 1023)), 1'($urandom));
				end else if (r < 78) begin
					send_request(CMD_GET, OFF_W'(off), 1'($urandom));
				end else if (r < 90) begin
					send_request(CMD_SET, OFF_W'(off), 1'($urandom));
				end else if (r < 95 && cursor > 0) begin
					// free a slot below the sweep so find lands inside the filled part
					send_request(CMD_SET, OFF_W'($urandom_range(0, cursor - 1)), 1'b0);
				end else begin
					send_request(CMD_RSVD, OFF_W'($urandom_range(0, 1023)), 1'($urandom));
				end
			end
		end

		drain_results();
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/bam_pkg.sv
sv/bam_ram.sv
sv/bitmap_allocation_map_core.sv
test/bam_checker.sv
test/tb.sv
